// ===== hdl/rc4ks_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 key schedule package
// Shared constants, register map and the structs that pass between the
// configuration block, the sequencer and the permutation memory.
// ----------------------------------------------------------------------------
package rc4ks_pkg;

  localparam int unsigned KEY_MAX_BYTES = 12;
  localparam int unsigned KEY_WORDS     = KEY_MAX_BYTES / 4;
  localparam int unsigned STORE_DEPTH   = 256;
  localparam int unsigned ADDR_W        = 8;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned PADDR_W       = 4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_KEY_WORD_ZERO = 2'd0;
  localparam logic [1:0] REG_KEY_WORD_ONE  = 2'd1;
  localparam logic [1:0] REG_KEY_WORD_TWO  = 2'd2;
  localparam logic [1:0] REG_KEY_LENGTH    = 2'd3;

  localparam logic [31:0]      KEY_WORD_ZERO_RST = 32'h55A8_4121;
  localparam logic [31:0]      KEY_WORD_ONE_RST  = 32'hBCFA_0440;
  localparam logic [31:0]      KEY_WORD_TWO_RST  = 32'h0000_5A4C;
  localparam logic [LEN_W-1:0] KEY_LENGTH_RST    = 4'd10;

  // Input kinds carried on tuser.
  localparam logic MODE_SCHEDULE = 1'b0;
  localparam logic MODE_READ     = 1'b1;

  typedef struct packed {
    logic [KEY_MAX_BYTES-1:0][7:0] key_bytes;
    logic [LEN_W-1:0]              key_len;   // already clamped to 1..KEY_MAX_BYTES
  } key_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hdl/rc4ks_ram.sv =====
// ----------------------------------------------------------------------------
// RC4 permutation memory
// 256 x 8 bit store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rc4ks_ram (
  input  logic                           clk_i,
  input  rc4ks_pkg::mem_req_t            req_i,
  output logic [rc4ks_pkg::DATA_W-1:0]   rdata_o
);

  logic [rc4ks_pkg::DATA_W-1:0] mem [rc4ks_pkg::STORE_DEPTH];
  logic [rc4ks_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // The read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rc4ks_cfg.sv =====
// ----------------------------------------------------------------------------
// RC4 key schedule configuration registers
// APB register file holding the key words and the key length.
// ----------------------------------------------------------------------------
module rc4ks_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rc4ks_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output rc4ks_pkg::key_cfg_t             cfg_o
);

  logic [31:0]                  key_w0_q, key_w1_q, key_w2_q;
  logic [rc4ks_pkg::LEN_W-1:0]  key_len_q;
  logic [1:0]                   reg_idx;
  logic                         wr_en;
  logic [rc4ks_pkg::LEN_W-1:0]  len_eff;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_w0_q  <= rc4ks_pkg::KEY_WORD_ZERO_RST;
      key_w1_q  <= rc4ks_pkg::KEY_WORD_ONE_RST;
      key_w2_q  <= rc4ks_pkg::KEY_WORD_TWO_RST;
      key_len_q <= rc4ks_pkg::KEY_LENGTH_RST;
    end else if (wr_en) begin
      case (reg_idx)
        rc4ks_pkg::REG_KEY_WORD_ZERO: key_w0_q  <= pwdata;
        rc4ks_pkg::REG_KEY_WORD_ONE:  key_w1_q  <= pwdata;
        rc4ks_pkg::REG_KEY_WORD_TWO:  key_w2_q  <= pwdata;
        rc4ks_pkg::REG_KEY_LENGTH:    key_len_q <= pwdata[rc4ks_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rc4ks_pkg::REG_KEY_WORD_ZERO: prdata = key_w0_q;
      rc4ks_pkg::REG_KEY_WORD_ONE:  prdata = key_w1_q;
      rc4ks_pkg::REG_KEY_WORD_TWO:  prdata = key_w2_q;
      rc4ks_pkg::REG_KEY_LENGTH:    prdata = {{(32-rc4ks_pkg::LEN_W){1'b0}}, key_len_q};
      default:                      prdata = '0;
    endcase
  end

  // A length of zero acts as one; anything above the key size is clamped.
  always_comb begin
    if (key_len_q == '0) begin
      len_eff = rc4ks_pkg::LEN_W'(1);
    end else if (key_len_q > rc4ks_pkg::LEN_W'(rc4ks_pkg::KEY_MAX_BYTES)) begin
      len_eff = rc4ks_pkg::LEN_W'(rc4ks_pkg::KEY_MAX_BYTES);
    end else begin
      len_eff = key_len_q;
    end
  end

  assign cfg_o.key_bytes = {key_w2_q, key_w1_q, key_w0_q};
  assign cfg_o.key_len   = len_eff;

endmodule

// ===== hdl/rc4ks_ctrl.sv =====
// ----------------------------------------------------------------------------
// RC4 key schedule sequencer
// Fills the memory with the identity, runs the swap steps by read, read,
// write, write, and serves entry reads through a registered output word.
// ----------------------------------------------------------------------------
module rc4ks_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rc4ks_pkg::key_cfg_t            cfg_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,
  output logic                           m_axis_tuser,
  output rc4ks_pkg::mem_req_t            mem_req_o,
  input  logic [rc4ks_pkg::DATA_W-1:0]   mem_rdata_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_RDI  = 3'd2;
  localparam logic [2:0] ST_RDJ  = 3'd3;
  localparam logic [2:0] ST_WRJ  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_RDQ  = 3'd6;
  localparam logic [2:0] ST_RESP = 3'd7;

  logic [2:0]                   state_q, state_d;
  logic [rc4ks_pkg::ADDR_W-1:0] i_q, i_d;
  logic [rc4ks_pkg::ADDR_W-1:0] j_q, j_d;
  logic [rc4ks_pkg::LEN_W-1:0]  k_q, k_d;
  logic [rc4ks_pkg::LEN_W-1:0]  k_inc;
  logic                         pend_q, pend_d;
  logic                         done_q, done_d;
  logic                         zero_q, zero_d;
  logic [rc4ks_pkg::ADDR_W-1:0] idx_q, idx_d;
  logic [rc4ks_pkg::DATA_W-1:0] si_q, si_d;
  logic [rc4ks_pkg::DATA_W-1:0] sj_q, sj_d;
  logic                         out_vld_q, out_vld_d;
  logic [7:0]                   out_data_q, out_data_d;
  logic                         out_user_q, out_user_d;
  logic [rc4ks_pkg::ADDR_W-1:0] j_next;
  logic                         out_free;

  assign k_inc    = k_q + rc4ks_pkg::LEN_W'(1);
  assign j_next   = j_q + mem_rdata_i + cfg_i.key_bytes[k_q];
  assign out_free = !out_vld_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    pend_d     = pend_q;
    done_d     = done_q;
    zero_d     = zero_q;
    idx_d      = idx_q;
    si_d       = si_q;
    sj_d       = sj_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    mem_req_o  = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == rc4ks_pkg::MODE_SCHEDULE) begin
            i_d     = '0;
            zero_d  = 1'b1;
            state_d = ST_FILL;
          end else if (done_q) begin
            idx_d   = s_axis_tdata;
            zero_d  = 1'b0;
            state_d = ST_RDQ;
          end else begin
            zero_d  = 1'b1;
            state_d = ST_RESP;
          end
        end
      end
      ST_FILL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = i_q;
        mem_req_o.wdata = i_q;
        i_d             = i_q + rc4ks_pkg::ADDR_W'(1);
        if (i_q == '1) begin
          j_d     = '0;
          k_d     = '0;
          pend_d  = 1'b0;
          state_d = ST_RDI;
        end
      end
      ST_RDI: begin
        // The deferred write of the previous step's S[i] shares this cycle.
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = i_q;
        mem_req_o.we    = pend_q;
        mem_req_o.waddr = i_q - rc4ks_pkg::ADDR_W'(1);
        mem_req_o.wdata = sj_q;
        state_d         = ST_RDJ;
      end
      ST_RDJ: begin
        si_d            = mem_rdata_i;
        j_d             = j_next;
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = j_next;
        state_d         = ST_WRJ;
      end
      ST_WRJ: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = si_q;
        sj_d            = mem_rdata_i;
        k_d             = (k_inc >= cfg_i.key_len) ? '0 : k_inc;
        pend_d          = 1'b1;
        if (i_q == '1) begin
          state_d = ST_FIN;
        end else begin
          i_d     = i_q + rc4ks_pkg::ADDR_W'(1);
          state_d = ST_RDI;
        end
      end
      ST_FIN: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = i_q;
        mem_req_o.wdata = sj_q;
        done_d          = 1'b1;
        state_d         = ST_RESP;
      end
      ST_RDQ: begin
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = idx_q;
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = zero_q ? '0 : mem_rdata_i;
          out_user_d = done_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    k_q        <= k_d;
    zero_q     <= zero_d;
    idx_q      <= idx_d;
    si_q       <= si_d;
    sj_q       <= sj_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

endmodule

// ===== hdl/rc4_key_schedule_permutation_core.sv =====
// ----------------------------------------------------------------------------
// RC4 key schedule permutation core
// Builds the RC4 state permutation from a programmable key and serves reads.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries the kind on s_axis_tuser (0 runs the key
//   schedule, 1 reads one entry) and the entry index on s_axis_tdata. Every
//   input word gives exactly one output word: the entry on m_axis_tdata and
//   the table-ready flag on m_axis_tuser. A schedule answers 0 with the flag
//   set; a read before any schedule answers 0 with the flag clear. The user
//   must write key and length over the APB port only while idle; not enforced.
// Sequence:
//   A read goes through ST_RDQ to ST_RESP, or straight to ST_RESP before any
//   schedule. A schedule fills the memory with the identity, runs each swap
//   step through ST_RDI, ST_RDJ and ST_WRJ, set by the single read and single
//   write port of the permutation memory, does the last write in ST_FIN and
//   loads the output word in ST_RESP. One input word is in work at a time.
// Reset and stalls:
//   Reset restores the default key and clears the table-ready flag; the
//   memory is not cleared. While the receiver stalls, the output word holds
//   and the next input word is taken but not answered until it is free.
// ----------------------------------------------------------------------------
module rc4_key_schedule_permutation_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rc4ks_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] entry_index
  input  logic                            s_axis_tuser,   // [0] mode
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [7:0] entry_value
  output logic                            m_axis_tuser    // [0] table_ready
);

  rc4ks_pkg::key_cfg_t          key_cfg;
  rc4ks_pkg::mem_req_t          mem_req;
  logic [rc4ks_pkg::DATA_W-1:0] mem_rdata;

  rc4ks_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (key_cfg)
  );

  rc4ks_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rc4ks_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (key_cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

endmodule
